### rtl/drt_pkg.sv
package drt_pkg;

	localparam int unsigned DW = 32;
	localparam int unsigned CW = 16;
	localparam int unsigned DIV_STEPS = 64;

	localparam logic [CW-1:0] INTERVAL_RESET = 16'd2016;
	localparam logic [CW-1:0] SPACING_RESET = 16'd60;
	localparam logic [DW-1:0] DIFF_ONE = 32'h0001_0000;

	// register index on the configuration port
	typedef enum logic [0:0] {
		REG_INTERVAL = 1'b0,
		REG_SPACING  = 1'b1
	} reg_idx_t;

	typedef logic [2:0] step_t;

	localparam step_t STEP_ACCEPT = 3'd0;
	localparam step_t STEP_WINDOW = 3'd1;
	localparam step_t STEP_MUL1   = 3'd2;
	localparam step_t STEP_MUL2   = 3'd3;
	localparam step_t STEP_DIV    = 3'd4;
	localparam step_t STEP_CLAMP  = 3'd5;
	localparam step_t STEP_EMIT   = 3'd6;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_WINDOW,
		OP_MUL1,
		OP_MUL2,
		OP_DIV,
		OP_CLAMP,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		WAIT_NONE,
		WAIT_IN,
		WAIT_OUT
	} wait_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_ADJUST,
		COND_SPECIAL,
		COND_DIV_MORE
	} cond_t;

	typedef struct packed {
		op_t   op;
		wait_t hold;
		cond_t jump;
		step_t target;
	} ctrl_t;

	// control store: hold a step while its wait condition is true,
	// then jump to target if the jump condition holds, else advance
	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		unique case (s)
			STEP_ACCEPT: w = '{OP_ACCEPT, WAIT_IN,   COND_NEVER,     STEP_ACCEPT};
			STEP_WINDOW: w = '{OP_WINDOW, WAIT_NONE, COND_NO_ADJUST, STEP_EMIT};
			STEP_MUL1:   w = '{OP_MUL1,   WAIT_NONE, COND_SPECIAL,   STEP_CLAMP};
			STEP_MUL2:   w = '{OP_MUL2,   WAIT_NONE, COND_NEVER,     STEP_ACCEPT};
			STEP_DIV:    w = '{OP_DIV,    WAIT_NONE, COND_DIV_MORE,  STEP_DIV};
			STEP_CLAMP:  w = '{OP_CLAMP,  WAIT_NONE, COND_NEVER,     STEP_ACCEPT};
			STEP_EMIT:   w = '{OP_EMIT,   WAIT_OUT,  COND_ALWAYS,    STEP_ACCEPT};
			default:     w = '{OP_NOP,    WAIT_NONE, COND_ALWAYS,    STEP_ACCEPT};
		endcase
		return w;
	endfunction

endpackage

### rtl/difficulty_retarget_unit.sv
// Difficulty retarget over fixed windows of adjust_interval valid blocks. Each
// input transfer yields exactly one result transfer carrying the difficulty
// (unsigned Q16.16) after that block and a flag set when the block closed a
// window and the difficulty was recomputed. A small microcode sequencer runs
// each item: an item that does not retarget goes from the window step to the
// emit step, a retarget whose elapsed time is not positive (or with zero
// difficulty) skips to the clamp step, and a full retarget runs the bit-serial
// restoring divider that produces one quotient bit of the 64-bit quotient per
// cycle. A new item is taken while the previous result still waits in the
// output register; the emit step holds until that result has been taken.
// Configuration writes take effect at the next clock edge; make them only while
// no item is in flight.
module difficulty_retarget_unit
	import drt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,

	input  logic          in_valid,
	output logic          in_ready,
	input  logic          block_valid,
	input  logic [DW-1:0] block_time,

	output logic          out_valid,
	input  logic          out_ready,
	output logic [DW-1:0] difficulty_out,
	output logic          retargeted,

	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [CW-1:0] cfg_data
);

	localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

	// control and architectural state
	step_t         step_q;
	logic [CW-1:0] interval_q;
	logic [CW-1:0] spacing_q;
	logic [CW-1:0] pos_q;
	logic [DW-1:0] start_q;
	logic [DW-1:0] diff_q;
	logic          out_valid_q;

	// datapath registers
	logic            bvalid_q;
	logic [DW-1:0]   time_q;
	logic            done_q;
	logic [DW-1:0]   sxi_q;
	logic [DW-1:0]   div_q;
	logic [2*DW-1:0] quo_q;
	logic [DW-1:0]   rem_q;
	logic [5:0]      cnt_q;
	logic [DW-1:0]   out_diff_q;
	logic            out_done_q;

	ctrl_t cw;
	logic  stall;
	logic  jump_taken;
	step_t step_d;

	logic [CW-1:0] pos_inc;
	logic          closes;
	logic          adjust;
	logic          special;
	logic [DW:0]   rem_shift;
	logic          sub_ok;
	logic [DW:0]   upper_sum;
	logic [DW-1:0] upper;
	logic [DW+1:0] lower_sum;
	logic [DW-1:0] lower;
	logic [DW-1:0] clamped;

	assign cw = ucode(step_q);

	assign in_ready = arst_n && (cw.hold == WAIT_IN);
	assign out_valid = out_valid_q;
	assign difficulty_out = out_diff_q;
	assign retargeted = out_done_q;

	always_comb begin
		pos_inc = pos_q + 16'd1;
		closes = (pos_inc == '0) || (pos_inc >= interval_q);
		adjust = bvalid_q && closes && (interval_q > 16'd1);
		special = (diff_q == '0) || (time_q <= start_q);

		rem_shift = {rem_q, quo_q[2*DW-1]};
		sub_ok = rem_shift >= {1'b0, div_q};

		upper_sum = {1'b0, diff_q} + 33'(DIFF_ONE);
		upper = upper_sum[DW] ? '1 : upper_sum[DW-1:0];
		lower_sum = {1'b0, diff_q, 1'b0} + {2'b00, diff_q};
		lower = lower_sum[DW+1:2];
		if (quo_q > {{DW{1'b0}}, upper}) begin
			clamped = upper;
		end else if (quo_q < {{DW{1'b0}}, lower}) begin
			clamped = lower;
		end else begin
			clamped = quo_q[DW-1:0];
		end
	end

	always_comb begin
		unique case (cw.hold)
			WAIT_IN:  stall = !in_valid;
			WAIT_OUT: stall = out_valid_q && !out_ready;
			default:  stall = 1'b0;
		endcase
		unique case (cw.jump)
			COND_ALWAYS:    jump_taken = 1'b1;
			COND_NO_ADJUST: jump_taken = !adjust;
			COND_SPECIAL:   jump_taken = special;
			COND_DIV_MORE:  jump_taken = (cnt_q != DIV_LAST);
			default:        jump_taken = 1'b0;
		endcase
		if (stall) begin
			step_d = step_q;
		end else if (jump_taken) begin
			step_d = cw.target;
		end else begin
			step_d = step_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_ACCEPT;
			interval_q <= INTERVAL_RESET;
			spacing_q <= SPACING_RESET;
			pos_q <= '0;
			start_q <= '0;
			diff_q <= DIFF_ONE;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_INTERVAL: interval_q <= cfg_data;
					REG_SPACING:  spacing_q <= cfg_data;
				endcase
			end
			if (cw.op == OP_WINDOW && bvalid_q) begin
				if (pos_q == '0) begin
					start_q <= time_q;
				end
				pos_q <= closes ? '0 : pos_inc;
			end
			if (cw.op == OP_CLAMP) begin
				diff_q <= clamped;
			end
			// load the result slot, else drop it once the transfer completes
			if (cw.op == OP_EMIT && !stall) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cw.op)
			OP_ACCEPT: begin
				if (in_valid) begin
					bvalid_q <= block_valid;
					time_q <= block_time;
				end
			end
			OP_WINDOW: begin
				done_q <= adjust;
			end
			OP_MUL1: begin
				sxi_q <= {16'd0, spacing_q} * {16'd0, interval_q};
				div_q <= time_q - start_q;
				// preset the quotient so the clamp picks the right bound
				if (diff_q == '0 || time_q < start_q) begin
					quo_q <= '0;
				end else begin
					quo_q <= '1;
				end
			end
			OP_MUL2: begin
				quo_q <= 64'(diff_q) * 64'(sxi_q);
				rem_q <= '0;
				cnt_q <= '0;
			end
			OP_DIV: begin
				if (sub_ok) begin
					rem_q <= DW'(rem_shift - {1'b0, div_q});
				end else begin
					rem_q <= rem_shift[DW-1:0];
				end
				quo_q <= {quo_q[2*DW-2:0], sub_ok};
				cnt_q <= cnt_q + 6'd1;
			end
			OP_EMIT: begin
				if (!stall) begin
					out_diff_q <= diff_q;
					out_done_q <= done_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cw.op == OP_EMIT))
		else $error("result slot loaded outside the emit step");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.op == OP_DIV) |-> (div_q != '0))
		else $error("divider running with a zero divisor");

	a_clamp_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.op == OP_CLAMP) |=> (diff_q <= $past(upper)))
		else $error("new difficulty above its upper bound");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (cw.op == OP_WINDOW))
		else $error("input transfer did not start the window step");

endmodule

### test/tb_difficulty_retarget_unit.sv
`timescale 1ns / 100ps

module tb_difficulty_retarget_unit;
	import drt_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 140;

	typedef struct packed {
		logic [DW-1:0] diff;
		logic          ret;
	} outcome_t;

	typedef enum logic {
		ROW_BLOCK,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		reg_idx_t      sel;
		logic [CW-1:0] value;
		logic          bval;
		logic [DW-1:0] btime;
		logic          typed;
		outcome_t      want;
	} stim_row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic          block_valid = 1'b0;
	logic [DW-1:0] block_time = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [DW-1:0] difficulty_out;
	logic          retargeted;
	logic          cfg_we = 1'b0;
	logic [0:0]    cfg_index = REG_INTERVAL;
	logic [CW-1:0] cfg_data = '0;

	// predictor state
	logic [CW-1:0] window_len = INTERVAL_RESET;
	logic [CW-1:0] spacing = SPACING_RESET;
	logic [CW-1:0] win_pos = '0;
	logic [DW-1:0] win_start = '0;
	logic [DW-1:0] cur_diff = DIFF_ONE;

	outcome_t  pending_outcomes[$];
	stim_row_t plan[$];
	int        mismatches = 0;
	int        send_gap_pct = 15;
	int        take_gap_pct = 45;
	int        stall = 0;

	difficulty_retarget_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.block_valid    (block_valid),
		.block_time     (block_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.difficulty_out (difficulty_out),
		.retargeted     (retargeted),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [DW-1:0] next_difficulty(input logic [DW-1:0] d,
			input logic [DW-1:0] start, input logic [DW-1:0] now,
			input logic [CW-1:0] len, input logic [CW-1:0] gap);
		logic [63:0] upper;
		logic [63:0] lower;
		logic [63:0] quot;
		upper = {32'd0, d} + {32'd0, DIFF_ONE};
		if (upper > 64'h0000_0000_FFFF_FFFF)
			upper = 64'h0000_0000_FFFF_FFFF;
		lower = ({32'd0, d} * 64'd3) >> 2;
		if (d == '0)
			return '0;
		if (now == start)
			return upper[DW-1:0];
		if (now < start)
			return lower[DW-1:0];
		quot = ({32'd0, d} * ({48'd0, gap} * {48'd0, len})) / {32'd0, now - start};
		if (quot > upper)
			return upper[DW-1:0];
		if (quot < lower)
			return lower[DW-1:0];
		return quot[DW-1:0];
	endfunction

	task automatic apply_block(input logic bval, input logic [DW-1:0] t,
			output outcome_t res);
		logic [CW-1:0] pos;
		res.ret = 1'b0;
		if (bval) begin
			if (win_pos == '0)
				win_start = t;
			pos = win_pos + 16'd1;
			if (pos == '0 || pos >= window_len) begin
				win_pos = '0;
				if (window_len > 16'd1) begin
					cur_diff = next_difficulty(cur_diff, win_start, t, window_len, spacing);
					res.ret = 1'b1;
				end
			end else begin
				win_pos = pos;
			end
		end
		res.diff = cur_diff;
	endtask

	// enter and leave at a falling edge; valid stays high on return
	task automatic offer_block(input logic bval, input logic [DW-1:0] t,
			input logic typed = 1'b0, input outcome_t want = '0);
		outcome_t res;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		block_valid <= bval;
		block_time <= t;
		do @(posedge clk); while (!in_ready);
		apply_block(bval, t, res);
		pending_outcomes.insert(pending_outcomes.size(), typed ? want : res);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
	endtask

	// leaves cfg_we high; the caller drops it
	task automatic write_reg(input reg_idx_t sel, input logic [CW-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		@(negedge clk);
		if (sel == REG_INTERVAL)
			window_len = value;
		else
			spacing = value;
	endtask

	function automatic void add_row(input stim_row_t row);
		plan.insert(plan.size(), row);
	endfunction

	function automatic stim_row_t block_row(input logic bval, input logic [DW-1:0] t);
		return '{ROW_BLOCK, REG_INTERVAL, 16'd0, bval, t, 1'b0, '0};
	endfunction

	function automatic stim_row_t checked_row(input logic bval, input logic [DW-1:0] t,
			input logic [DW-1:0] diff, input logic ret);
		return '{ROW_BLOCK, REG_INTERVAL, 16'd0, bval, t, 1'b1, '{diff, ret}};
	endfunction

	function automatic stim_row_t reg_row(input reg_idx_t sel, input logic [CW-1:0] value);
		return '{ROW_REG, sel, value, 1'b0, 32'd0, 1'b0, '0};
	endfunction

	always @(negedge clk)
		out_ready <= arst_n && ($urandom_range(0, 99) >= take_gap_pct);

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result difficulty_out %h retargeted %b",
					$time, difficulty_out, retargeted);
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				if (difficulty_out !== want.diff) begin
					$display("%0t: difficulty_out expected %h got %h",
						$time, want.diff, difficulty_out);
					mismatches++;
				end
				if (retargeted !== want.ret) begin
					$display("%0t: retargeted expected %b got %b",
						$time, want.ret, retargeted);
					mismatches++;
				end
			end
		end
	end

	initial begin
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall = 0;
			else
				stall++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic          reg_open;
		logic [CW-1:0] len;
		logic [CW-1:0] gap;
		logic [DW-1:0] t;
		logic [DW-1:0] t0;
		int            pick;

		add_row(checked_row(1'b0, 32'hFFFF_FFFF, DIFF_ONE, 1'b0));
		add_row(reg_row(REG_INTERVAL, 16'd2));
		add_row(checked_row(1'b1, 32'd0, DIFF_ONE, 1'b0));
		// equal timestamps: jump to the upper bound
		add_row(checked_row(1'b1, 32'd0, 32'd131072, 1'b1));
		add_row(checked_row(1'b1, 32'hFFFF_FFFF, 32'd131072, 1'b0));
		add_row(checked_row(1'b0, 32'd0, 32'd131072, 1'b0));
		// time went backwards: drop to the lower bound
		add_row(checked_row(1'b1, 32'd0, 32'd98304, 1'b1));
		add_row(checked_row(1'b1, 32'd0, 32'd98304, 1'b0));
		add_row(checked_row(1'b1, 32'hFFFF_FFFF, 32'd73728, 1'b1));
		add_row(block_row(1'b1, 32'd1000));
		add_row(block_row(1'b1, 32'd1120));
		add_row(reg_row(REG_SPACING, 16'hFFFF));
		add_row(block_row(1'b1, 32'd5));
		add_row(block_row(1'b1, 32'd6));
		add_row(reg_row(REG_SPACING, 16'd1));
		// single-block windows never adjust
		add_row(reg_row(REG_INTERVAL, 16'd1));
		add_row(checked_row(1'b1, 32'd7, 32'd139264, 1'b0));
		add_row(checked_row(1'b1, 32'd7, 32'd139264, 1'b0));
		add_row(reg_row(REG_INTERVAL, 16'd0));
		add_row(checked_row(1'b1, 32'd9, 32'd139264, 1'b0));
		// shrink the window while it is open: closes on the next block
		add_row(reg_row(REG_INTERVAL, 16'hFFFF));
		add_row(block_row(1'b1, 32'd100));
		add_row(block_row(1'b1, 32'd130));
		add_row(block_row(1'b1, 32'd160));
		add_row(reg_row(REG_INTERVAL, 16'd3));
		add_row(block_row(1'b1, 32'd190));
		add_row(reg_row(REG_SPACING, 16'd60));
		add_row(reg_row(REG_INTERVAL, 16'd4));
		add_row(block_row(1'b1, 32'd200));
		add_row(block_row(1'b1, 32'd260));
		add_row(block_row(1'b1, 32'd320));
		add_row(block_row(1'b1, 32'd380));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		reg_open = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				if (!reg_open)
					drain();
				write_reg(plan[i].sel, plan[i].value);
				reg_open = 1'b1;
			end else begin
				if (reg_open)
					cfg_we <= 1'b0;
				reg_open = 1'b0;
				offer_block(plan[i].bval, plan[i].btime, plan[i].typed, plan[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			unique case (ph * 3 / PHASES)
				0: begin
					send_gap_pct = 15;
					take_gap_pct = 45;
				end
				1: begin
					send_gap_pct = 45;
					take_gap_pct = 15;
				end
				default: begin
					send_gap_pct = 0;
					take_gap_pct = 0;
				end
			endcase
			pick = $urandom_range(0, 11);
			unique case (pick)
				0: len = 16'd1;
				1: len = 16'd0;
				2: len = 16'hFFFF;
				default: len = $urandom_range(2, 12);
			endcase
			unique case (pick)
				3: gap = 16'hFFFF;
				4: gap = 16'd1;
				default: gap = $urandom_range(1, 65535);
			endcase
			drain();
			write_reg(REG_INTERVAL, len);
			write_reg(REG_SPACING, gap);
			cfg_we <= 1'b0;
			t = $urandom;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					offer_block(1'b0, $urandom);
				end else begin
					if (pick < 14)
						t = $urandom;
					else if (pick < 22 && pick >= 18)
						t = t - $urandom_range(1, 4 * int'(gap));
					else if (pick >= 22)
						t = t + $urandom_range(int'(gap) / 2, 2 * int'(gap));
					offer_block(1'b1, t);
				end
			end
		end

		// drive the difficulty down to zero, then show it sticks there
		drain();
		write_reg(REG_INTERVAL, 16'd2);
		write_reg(REG_SPACING, 16'd60);
		cfg_we <= 1'b0;
		if (win_pos != '0)
			offer_block(1'b1, $urandom);
		for (int k = 0; k < 150 && cur_diff != '0; k++) begin
			t0 = $urandom;
			offer_block(1'b1, t0);
			offer_block(1'b1, t0 - $urandom_range(1, 1000));
		end
		for (int k = 0; k < 10; k++) begin
			t0 = $urandom;
			offer_block(1'b1, t0);
			offer_block(1'b1, t0);
			offer_block(1'b1, t0 + $urandom_range(30, 240));
		end

		drain();
		repeat (100) @(negedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
